[design/sdfp_pkg.sv]
package sdfp_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int SHAPE_W   = 4;

  // Magnitude width of a length operand, root width and radicand width.
  localparam int LW  = WORD_BITS + 2;
  localparam int RTW = LW + 1;
  localparam int RW  = 2 * RTW;
  // Signed width of the final arithmetic and of a constant product.
  localparam int DW  = WORD_BITS + 8;
  localparam int MCW = FRAC_BITS + 1;
  localparam int PW  = DW + MCW;

  localparam longint Q_ONE    = longint'(1) << FRAC_BITS;
  localparam longint Q_HALF   = longint'(1) << (FRAC_BITS - 1);
  localparam longint Q_C07    = (7 * Q_ONE + 5) / 10;
  localparam longint Q_C03    = (3 * Q_ONE + 5) / 10;
  localparam longint Q_C01    = (Q_ONE + 5) / 10;
  localparam longint Q_INVSQ3 = (57735027 * Q_ONE + 50000000) / 100000000;
  localparam longint Q_SQ3H   = (866025 * Q_ONE + 500000) / 1000000;
  localparam longint WORD_MAX = (longint'(1) << (WORD_BITS - 1)) - 1;
  localparam longint WORD_MIN = -WORD_MAX - 1;

  localparam logic [SHAPE_W-1:0] SHAPE_SPHERE = 4'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_BOX    = 4'd2;
  localparam logic [SHAPE_W-1:0] SHAPE_TORUS  = 4'd3;
  localparam logic [SHAPE_W-1:0] SHAPE_CYL    = 4'd4;
  localparam logic [SHAPE_W-1:0] SHAPE_OCTA   = 4'd5;
  localparam logic [SHAPE_W-1:0] SHAPE_RBOX   = 4'd6;
  localparam logic [SHAPE_W-1:0] SHAPE_HEX    = 4'd7;
  localparam logic [SHAPE_W-1:0] SHAPE_CONE   = 4'd8;
  localparam logic [SHAPE_W-1:0] SHAPE_RESET  = SHAPE_BOX;

  typedef struct packed {
    logic [SHAPE_W-1:0]          shape;
    logic signed [WORD_BITS-1:0] x;
    logic signed [WORD_BITS-1:0] y;
    logic signed [WORD_BITS-1:0] z;
    logic [RTW-1:0]              len1;
  } side_t;

endpackage

[design/sdfp_pos_if.sv]
interface sdfp_pos_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sdfp_pkg::WORD_BITS-1:0] pos_x;
  logic signed [sdfp_pkg::WORD_BITS-1:0] pos_y;
  logic signed [sdfp_pkg::WORD_BITS-1:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

[design/sdfp_dist_if.sv]
interface sdfp_dist_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sdfp_pkg::WORD_BITS-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink (input valid, input distance, output ready);
endinterface

[design/sdfp_len.sv]
module sdfp_len (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [sdfp_pkg::LW-1:0]   a_i,
  input  logic [sdfp_pkg::LW-1:0]   b_i,
  input  logic [sdfp_pkg::LW-1:0]   c_i,
  input  sdfp_pkg::side_t           side_i,
  output logic                      vld_o,
  output logic [sdfp_pkg::RTW-1:0]  len_o,
  output sdfp_pkg::side_t           side_o
);

  localparam int LW   = sdfp_pkg::LW;
  localparam int RTW  = sdfp_pkg::RTW;
  localparam int RW   = sdfp_pkg::RW;
  localparam int REMW = RTW + 3;

  logic                  sq_vld_q;
  logic [2*LW-1:0]       sqa_q, sqb_q, sqc_q;
  sdfp_pkg::side_t       sq_side_q;

  logic                  vld_q  [0:RTW];
  logic [RW-1:0]         rad_q  [0:RTW];
  logic [REMW-1:0]       rem_q  [0:RTW];
  logic [RTW-1:0]        root_q [0:RTW];
  sdfp_pkg::side_t       side_q [0:RTW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      sq_vld_q <= vld_i;
      vld_q[0] <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqa_q     <= a_i * a_i;
      sqb_q     <= b_i * b_i;
      sqc_q     <= c_i * c_i;
      sq_side_q <= side_i;
      rad_q[0]  <= RW'(sqa_q) + RW'(sqb_q) + RW'(sqc_q);
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      side_q[0] <= sq_side_q;
    end
  end

  for (genvar k = 0; k < RTW; k++) begin : g_step
    logic [REMW-1:0] rem_sh, trial;
    logic            take;

    assign rem_sh = {rem_q[k][REMW-3:0], rad_q[k][RW-1:RW-2]};
    assign trial  = {1'b0, root_q[k], 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k+1]  <= {rad_q[k][RW-3:0], 2'b00};
        rem_q[k+1]  <= take ? rem_sh - trial : rem_sh;
        root_q[k+1] <= {root_q[k][RTW-2:0], take};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign vld_o  = vld_q[RTW];
  assign len_o  = root_q[RTW];
  assign side_o = side_q[RTW];

endmodule

[design/sdf_primitive_distance_core.sv]
// Signed distance from a Q16.16 point to the primitive chosen by the shape register, one point
// per clock when the output is not stalled. Every point passes an input register, two chained
// vector-length units of 37 stages each (three squares, their sum and a square root that
// settles one result bit per stage), two stages for the constant products and the output
// register. A stall at the output holds the whole pipeline. The shape register should be
// written only while no point is in flight.
module sdf_primitive_distance_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sdfp_pkg::SHAPE_W-1:0]        cfg_wdata_i,
  sdfp_pos_if.sink                            pos_i,
  sdfp_dist_if.source                         dist_o
);

  localparam int W    = sdfp_pkg::WORD_BITS;
  localparam int FB   = sdfp_pkg::FRAC_BITS;
  localparam int LW   = sdfp_pkg::LW;
  localparam int RTW  = sdfp_pkg::RTW;
  localparam int DW   = sdfp_pkg::DW;
  localparam int MCW  = sdfp_pkg::MCW;
  localparam int PW   = sdfp_pkg::PW;
  localparam int SW   = sdfp_pkg::SHAPE_W;

  localparam logic [LW-1:0]        L_ONE    = LW'(sdfp_pkg::Q_ONE);
  localparam logic [LW-1:0]        L_HALF   = LW'(sdfp_pkg::Q_HALF);
  localparam logic signed [DW-1:0] D_ONE    = DW'(sdfp_pkg::Q_ONE);
  localparam logic signed [DW-1:0] D_HALF   = DW'(sdfp_pkg::Q_HALF);
  localparam logic signed [DW-1:0] D_C07    = DW'(sdfp_pkg::Q_C07);
  localparam logic signed [DW-1:0] D_C03    = DW'(sdfp_pkg::Q_C03);
  localparam logic signed [DW-1:0] D_C01    = DW'(sdfp_pkg::Q_C01);
  localparam logic signed [DW-1:0] D_WMAX   = DW'(sdfp_pkg::WORD_MAX);
  localparam logic signed [DW-1:0] D_WMIN   = DW'(sdfp_pkg::WORD_MIN);
  localparam logic [MCW-1:0]       M_HALF   = MCW'(sdfp_pkg::Q_HALF);
  localparam logic [MCW-1:0]       M_INVSQ3 = MCW'(sdfp_pkg::Q_INVSQ3);
  localparam logic [MCW-1:0]       M_SQ3H   = MCW'(sdfp_pkg::Q_SQ3H);
  localparam logic [PW-1:0]        P_HALF   = PW'(sdfp_pkg::Q_HALF);

  function automatic logic [LW-1:0] mag_w(logic signed [W-1:0] v);
    logic [LW-1:0] e;
    e = {{(LW-W){v[W-1]}}, v};
    return v[W-1] ? LW'(-e) : e;
  endfunction

  function automatic logic signed [DW-1:0] ext_w(logic signed [W-1:0] v);
    return $signed({{(DW-W){v[W-1]}}, v});
  endfunction

  function automatic logic signed [DW-1:0] ext_l(logic [RTW-1:0] v);
    return $signed({{(DW-RTW){1'b0}}, v});
  endfunction

  function automatic logic signed [DW-1:0] smax(logic signed [DW-1:0] a,
                                                logic signed [DW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [DW-1:0] smin(logic signed [DW-1:0] a,
                                                logic signed [DW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [LW-1:0] sub_clip(logic [LW-1:0] a, logic [LW-1:0] c);
    return (a > c) ? a - c : '0;
  endfunction

  logic                   en;
  logic [SW-1:0]          shape_q;

  logic                   p0_vld_q;
  sdfp_pkg::side_t        p0_side_q;
  logic [LW-1:0]          ax0, ay0, az0, a1, b1, c1;

  logic                   l1_vld;
  logic [RTW-1:0]         l1_len;
  sdfp_pkg::side_t        l1_side, l2_in_side;
  logic [LW-1:0]          a2, b2;
  logic signed [DW-1:0]   tor_a;

  logic                   l2_vld;
  logic [RTW-1:0]         l2_len;
  sdfp_pkg::side_t        l2_side;

  logic signed [DW-1:0]   sx, sy, sz, dax, day, daz, dl1, dl2;
  logic signed [DW-1:0]   f1_a_d, f1_b_d, op1, op2;
  logic [MCW-1:0]         mc1, mc2;
  logic [DW-1:0]          mag1, mag2;

  logic                   f1_vld_q;
  logic [SW-1:0]          f1_shape_q;
  logic signed [DW-1:0]   f1_a_q, f1_b_q;
  logic [PW-1:0]          f1_prod1_q, f1_prod2_q;
  logic                   f1_neg1_q, f1_neg2_q;

  logic [PW-1:0]          rnd1, rnd2;
  logic signed [DW-1:0]   p1_d, p2_d;

  logic                   f2_vld_q;
  logic [SW-1:0]          f2_shape_q;
  logic signed [DW-1:0]   f2_a_q, f2_b_q, f2_p1_q, f2_p2_q;

  logic signed [DW-1:0]   res, hex_t;
  logic signed [W-1:0]    dist_d;
  logic                   out_vld_q;
  logic signed [W-1:0]    out_dist_q;

  assign en          = !out_vld_q || dist_o.ready;
  assign pos_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= sdfp_pkg::SHAPE_RESET;
    end else if (cfg_we_i) begin
      shape_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q  <= 1'b0;
      f1_vld_q  <= 1'b0;
      f2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      p0_vld_q  <= pos_i.valid;
      f1_vld_q  <= l2_vld;
      f2_vld_q  <= f1_vld_q;
      out_vld_q <= f2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_side_q.shape <= shape_q;
      p0_side_q.x     <= pos_i.pos_x;
      p0_side_q.y     <= pos_i.pos_y;
      p0_side_q.z     <= pos_i.pos_z;
      p0_side_q.len1  <= '0;
    end
  end

  // Operands of the first vector length.
  always_comb begin
    ax0 = mag_w(p0_side_q.x);
    ay0 = mag_w(p0_side_q.y);
    az0 = mag_w(p0_side_q.z);
    unique case (p0_side_q.shape)
      sdfp_pkg::SHAPE_BOX: begin
        a1 = sub_clip(ax0, L_ONE);
        b1 = sub_clip(ay0, L_ONE);
        c1 = sub_clip(az0, L_ONE);
      end
      sdfp_pkg::SHAPE_RBOX: begin
        a1 = sub_clip(ax0, L_HALF);
        b1 = sub_clip(ay0, L_HALF);
        c1 = sub_clip(az0, L_HALF);
      end
      sdfp_pkg::SHAPE_TORUS, sdfp_pkg::SHAPE_CYL, sdfp_pkg::SHAPE_CONE: begin
        a1 = ax0;
        b1 = az0;
        c1 = '0;
      end
      sdfp_pkg::SHAPE_OCTA, sdfp_pkg::SHAPE_HEX: begin
        a1 = '0;
        b1 = '0;
        c1 = '0;
      end
      default: begin
        a1 = ax0;
        b1 = ay0;
        c1 = az0;
      end
    endcase
  end

  sdfp_len u_len1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (p0_vld_q),
    .a_i    (a1),
    .b_i    (b1),
    .c_i    (c1),
    .side_i (p0_side_q),
    .vld_o  (l1_vld),
    .len_o  (l1_len),
    .side_o (l1_side)
  );

  // Operands of the second vector length.
  always_comb begin
    l2_in_side      = l1_side;
    l2_in_side.len1 = l1_len;
    tor_a           = ext_l(l1_len) - D_C07;
    unique case (l1_side.shape)
      sdfp_pkg::SHAPE_TORUS: begin
        a2 = tor_a[DW-1] ? LW'(-tor_a) : LW'(tor_a);
        b2 = mag_w(l1_side.y);
      end
      sdfp_pkg::SHAPE_CYL: begin
        a2 = sub_clip(LW'(l1_len), L_ONE);
        b2 = sub_clip(mag_w(l1_side.y), L_HALF);
      end
      default: begin
        a2 = '0;
        b2 = '0;
      end
    endcase
  end

  sdfp_len u_len2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (l1_vld),
    .a_i    (a2),
    .b_i    (b2),
    .c_i    ('0),
    .side_i (l2_in_side),
    .vld_o  (l2_vld),
    .len_o  (l2_len),
    .side_o (l2_side)
  );

  always_comb begin
    sx     = ext_w(l2_side.x);
    sy     = ext_w(l2_side.y);
    sz     = ext_w(l2_side.z);
    dax    = sx[DW-1] ? -sx : sx;
    day    = sy[DW-1] ? -sy : sy;
    daz    = sz[DW-1] ? -sz : sz;
    dl1    = ext_l(l2_side.len1);
    dl2    = ext_l(l2_len);
    f1_a_d = '0;
    f1_b_d = '0;
    op1    = '0;
    op2    = '0;
    mc1    = '0;
    mc2    = '0;
    unique case (l2_side.shape)
      sdfp_pkg::SHAPE_BOX: begin
        f1_a_d = dl1;
        f1_b_d = smin(smax(smax(dax, day), daz) - D_ONE, '0);
      end
      sdfp_pkg::SHAPE_TORUS: begin
        f1_a_d = dl2 - D_C03;
      end
      sdfp_pkg::SHAPE_CYL: begin
        f1_a_d = dl2;
        f1_b_d = smin(smax(dl1 - D_ONE, day - D_HALF), '0);
      end
      sdfp_pkg::SHAPE_OCTA: begin
        op1 = dax + day + daz - D_ONE;
        mc1 = M_INVSQ3;
      end
      sdfp_pkg::SHAPE_RBOX: begin
        f1_a_d = dl1 - D_C01;
      end
      sdfp_pkg::SHAPE_HEX: begin
        op1    = dax;
        mc1    = M_SQ3H;
        op2    = daz;
        mc2    = M_HALF;
        f1_a_d = daz;
        f1_b_d = day - D_HALF;
      end
      sdfp_pkg::SHAPE_CONE: begin
        op1    = dl1 - D_HALF;
        mc1    = M_HALF;
        op2    = sy;
        mc2    = M_SQ3H;
        f1_b_d = -sy - D_ONE;
      end
      default: begin
        f1_a_d = dl1 - D_ONE;
      end
    endcase
    mag1 = op1[DW-1] ? DW'(-op1) : DW'(op1);
    mag2 = op2[DW-1] ? DW'(-op2) : DW'(op2);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_shape_q <= l2_side.shape;
      f1_a_q     <= f1_a_d;
      f1_b_q     <= f1_b_d;
      f1_prod1_q <= PW'(mag1) * PW'(mc1);
      f1_prod2_q <= PW'(mag2) * PW'(mc2);
      f1_neg1_q  <= op1[DW-1];
      f1_neg2_q  <= op2[DW-1];
    end
  end

  always_comb begin
    rnd1 = (f1_prod1_q + P_HALF) >> FB;
    rnd2 = (f1_prod2_q + P_HALF) >> FB;
    p1_d = f1_neg1_q ? -$signed(rnd1[DW-1:0]) : $signed(rnd1[DW-1:0]);
    p2_d = f1_neg2_q ? -$signed(rnd2[DW-1:0]) : $signed(rnd2[DW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f2_shape_q <= f1_shape_q;
      f2_a_q     <= f1_a_q;
      f2_b_q     <= f1_b_q;
      f2_p1_q    <= p1_d;
      f2_p2_q    <= p2_d;
    end
  end

  always_comb begin
    hex_t = smax(f2_p1_q + f2_p2_q, f2_a_q) - D_HALF;
    unique case (f2_shape_q)
      sdfp_pkg::SHAPE_BOX, sdfp_pkg::SHAPE_CYL: res = f2_a_q + f2_b_q;
      sdfp_pkg::SHAPE_OCTA:                      res = f2_p1_q;
      sdfp_pkg::SHAPE_HEX:                       res = smax(f2_b_q, hex_t);
      sdfp_pkg::SHAPE_CONE: res = smax(f2_p1_q + f2_p2_q - D_ONE, f2_b_q);
      default:                                   res = f2_a_q;
    endcase
    priority if (res > D_WMAX) begin
      dist_d = W'(D_WMAX);
    end else if (res < D_WMIN) begin
      dist_d = W'(D_WMIN);
    end else begin
      dist_d = W'(res);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_dist_q <= dist_d;
    end
  end

  assign dist_o.valid    = out_vld_q;
  assign dist_o.distance = out_dist_q;

endmodule

[design/sdfp_checker.sv]
module sdfp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic pos_ready_i,
  input logic dist_valid_i,
  input logic dist_ready_i
);

  // A result that is not taken stays offered.
  a_dist_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_valid_i && !dist_ready_i |=> dist_valid_i)
    else $error("result withdrawn before its transfer");

  // An empty output stage always lets a new point in.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dist_valid_i |-> pos_ready_i)
    else $error("input blocked while the output stage is empty");

  // A blocked result stalls the input side.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_valid_i && !dist_ready_i |-> !pos_ready_i)
    else $error("input taken while the pipeline is stalled");

  // Ready follows the output side alone.
  a_ready_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_ready_i |-> pos_ready_i)
    else $error("input blocked while the output is taken");

endmodule

bind sdf_primitive_distance_core sdfp_checker u_sdfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pos_ready_i  (pos_i.ready),
  .dist_valid_i (dist_o.valid),
  .dist_ready_i (dist_o.ready)
);
